FILE: rtl/core/tpdc_pkg.sv
// Shared constants, types and the divider step function for the timer prescale calculator.
package tpdc_pkg;

  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned FIN_W   = 20;  // in-range frequencies fit here
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned PRE_W   = 8;
  localparam int unsigned REM_W   = 22;  // holds the 2457600 dividend and any divisor
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned QIDX_W  = 4;
  localparam int unsigned TRIAL_W = REM_W + COUNT_W;
  localparam int unsigned NUM_MODES = 8;
  localparam int unsigned BITS_PER_STAGE = 3;

  localparam logic [REM_W-1:0]   CLOCK_HZ  = REM_W'(2457600);
  localparam logic [FREQ_W-1:0]  FREQ_MIN  = FREQ_W'(48);
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = FREQ_W'(614400);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(256);

  localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(0);

  localparam logic [PRE_W-1:0] PRESCALE_BY_MODE [NUM_MODES] =
    '{8'd0, 8'd4, 8'd10, 8'd16, 8'd50, 8'd64, 8'd100, 8'd200};

  // lower band edge for modes 1..7; entry 0 unused
  localparam logic [FIN_W-1:0] BAND_FLOOR [NUM_MODES] =
    '{20'd0, 20'd2400, 20'd960, 20'd600, 20'd192, 20'd150, 20'd96, 20'd48};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REM_W-1:0]  divisor;
  } front_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [REM_W-1:0]   divisor;
    logic [REM_W-1:0]   rem;
    logic [COUNT_W-1:0] quot;
  } div_t;

  // Restoring division: resolve three quotient bits from bit 'base' down.
  function automatic div_t div_step3(div_t s, int unsigned base);
    logic [TRIAL_W-1:0] trial;
    div_t r;
    r = s;
    for (int j = 0; j < BITS_PER_STAGE; j++) begin
      trial = {{COUNT_W{1'b0}}, r.divisor} << (base - j);
      if ({{COUNT_W{1'b0}}, r.rem} >= trial) begin
        r.rem = r.rem - trial[REM_W-1:0];
        r.quot[QIDX_W'(base - j)] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/timer_prescale_divisor_calc.sv
// Top level of the timer prescale calculator for a 2.4576 MHz timer clock.
// Usage:
//   Input channel (tick_valid/tick_ready) carries a wanted tick frequency
//   in hertz on tick_freq. Output channel (result_valid/result_ready) returns
//   one transaction per request: prescale_mode (0 = rejected, 1..7 = divide
//   by 4, 10, 16, 50, 64, 100, 200) and timer_count, the quotient of
//   2457600 by prescale times frequency (1..256, 0 when rejected).
//   Frequencies outside 48..614400 are rejected.
// Pipeline: an accepted request passes through five register stages before
//   result_valid: band select, prescale multiply, and three divider stages
//   that each resolve three quotient bits.
// Throughput: one transaction per cycle; a new request enters every cycle
//   while results drain.
// Stall: when result_ready is low, a full stage holds its item and empty
//   stages ahead of it still fill; tick_ready drops once every stage is full.
// Reset: rst clears all stage valid bits; no request is in flight afterward.
module timer_prescale_divisor_calc (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick_valid,
  output logic                          tick_ready,
  input  logic [tpdc_pkg::FREQ_W-1:0]   tick_freq,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [tpdc_pkg::MODE_W-1:0]   prescale_mode,
  output logic [tpdc_pkg::COUNT_W-1:0]  timer_count
);
  import tpdc_pkg::*;

  logic   front_valid;
  logic   front_ready;
  front_t front_data;

  tpdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick_valid),
    .in_ready  (tick_ready),
    .freq      (tick_freq),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  tpdc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .mode      (prescale_mode),
    .count     (timer_count)
  );

`ifndef ASSERT_OFF
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && prescale_mode == MODE_NONE |-> timer_count == '0)
    else $error("rejected result has nonzero count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && prescale_mode != MODE_NONE |->
      timer_count != '0 && timer_count <= COUNT_MAX)
    else $error("timer count out of range");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> tick_ready)
    else $error("pipeline stalls while output drains");
`endif

endmodule

FILE: rtl/core/tpdc_front.sv
// Band select and prescale multiply: two register stages.
module tpdc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpdc_pkg::FREQ_W-1:0]   freq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tpdc_pkg::front_t              out_data
);
  import tpdc_pkg::*;

  logic              valid1;
  logic [MODE_W-1:0] mode1;
  logic [FIN_W-1:0]  freq1;
  logic              ready1;
  logic [MODE_W-1:0] mode1_next;

  logic   valid2;
  front_t data2;
  logic   ready2;
  logic [PRE_W+FIN_W-1:0] product;

  // pick the smallest divide whose band floor the frequency reaches
  always_comb begin
    mode1_next = MODE_NONE;
    if (freq >= FREQ_MIN && freq <= FREQ_MAX) begin
      for (int m = NUM_MODES - 1; m >= 1; m--) begin
        if (freq[FIN_W-1:0] >= BAND_FLOOR[m]) mode1_next = MODE_W'(m);
      end
    end
  end

  assign ready2 = !valid2 || out_ready;
  assign ready1 = !valid1 || ready2;
  assign in_ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (ready1) begin
      valid1 <= in_valid;
    end
    if (in_valid && ready1) begin
      mode1 <= mode1_next;
      freq1 <= (mode1_next == MODE_NONE) ? '0 : freq[FIN_W-1:0];
    end
  end

  // out-of-range items carry a zero divisor
  assign product = PRESCALE_BY_MODE[mode1] * freq1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (ready2) begin
      valid2 <= valid1;
    end
    if (valid1 && ready2) begin
      data2.mode    <= mode1;
      data2.divisor <= product[REM_W-1:0];
    end
  end

  assign out_valid = valid2;
  assign out_data  = data2;

endmodule

FILE: rtl/core/tpdc_divider.sv
// Three-stage restoring divider of the timer clock by the prescaled frequency.
module tpdc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tpdc_pkg::front_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpdc_pkg::MODE_W-1:0]   mode,
  output logic [tpdc_pkg::COUNT_W-1:0]  count
);
  import tpdc_pkg::*;

  localparam int unsigned NUM_STAGES = COUNT_W / BITS_PER_STAGE;

  logic valid [NUM_STAGES];
  logic ready [NUM_STAGES];
  div_t stage [NUM_STAGES];
  div_t head;

  always_comb begin
    head.mode    = in_data.mode;
    head.divisor = in_data.divisor;
    head.rem     = CLOCK_HZ;
    head.quot    = '0;
  end

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    localparam int unsigned BASE = COUNT_W - 1 - g * BITS_PER_STAGE;
    logic valid_prev;
    div_t data_prev;

    if (g == 0) begin : g_first
      assign valid_prev = in_valid;
      assign data_prev  = head;
    end else begin : g_rest
      assign valid_prev = valid[g-1];
      assign data_prev  = stage[g-1];
    end

    if (g == NUM_STAGES - 1) begin : g_last
      assign ready[g] = !valid[g] || out_ready;
    end else begin : g_mid
      assign ready[g] = !valid[g] || ready[g+1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g] <= 1'b0;
      end else if (ready[g]) begin
        valid[g] <= valid_prev;
      end
      if (valid_prev && ready[g]) begin
        stage[g] <= div_step3(data_prev, BASE);
      end
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = valid[NUM_STAGES-1];
  assign mode      = stage[NUM_STAGES-1].mode;
  // rejected items divide by zero; force their count to zero
  assign count     = (stage[NUM_STAGES-1].mode == MODE_NONE) ? '0
                                                               : stage[NUM_STAGES-1].quot;

endmodule
